/* rtl/bankers_safety_check_top_defines.svh */
// Assertion macros used by the safety-check top module.
`ifndef BANKERS_SAFETY_CHECK_TOP_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
// Shared widths, codes and defaults of the safety-check block.
package bsc_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 16;
    localparam int VALUE_BITS_DEF    = 16;

    localparam int ACTION_BITS    = 3;
    localparam int INDEX_BITS     = 4;
    localparam int AMOUNT_BITS    = 16;
    localparam int STATUS_BITS    = 3;
    localparam int COUNT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [ACTION_BITS-1:0] ACT_LOAD_MAX   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD_AVAIL = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REQUEST    = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_RUN        = 3'd4;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACCEPTED      = 3'd0,
        ST_OUT_OF_BOUNDS = 3'd1,
        ST_GRANTED       = 3'd2,
        ST_NEGATIVE_NEED = 3'd3,
        ST_UNSAFE        = 3'd4
    } status_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROCESS_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESOURCE_COUNT = 1'd1;

endpackage

/* rtl/bsc_if.sv */
// Command and result channel interfaces of the safety-check block.
interface bsc_cmd_if
    import bsc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [INDEX_BITS-1:0]  process_index;
    logic [INDEX_BITS-1:0]  resource_index;
    logic [AMOUNT_BITS-1:0] amount;

    modport source (output valid, action, process_index, resource_index, amount,
                    input ready);
    modport sink   (input valid, action, process_index, resource_index, amount,
                    output ready);
endinterface

interface bsc_res_if
    import bsc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  granted_process;
    logic                   last;

    modport source (output valid, status, granted_process, last, input ready);
    modport sink   (input valid, status, granted_process, last, output ready);
endinterface

/* rtl/bankers_safety_check_top.sv */
// Banker's safety check: tables, run sequencer and result register.
//
// Usage: items arrive on cmd (valid/ready) and results leave on res (valid/ready).
// Load maximum, load available, request, release and bad items give one result
// each. A run gives one granted result per process in safe order, or a single
// negative-need result, or the grants found so far followed by an unsafe result,
// or, with no processes, a single accepted result; the final result of every
// item carries last. The user must write the config port (cfg_we, cfg_index,
// cfg_data), which sets process_count and resource_count, only while idle; the
// block itself does not enforce it. Flow: a single-entry item is accepted and
// its result is registered when its microcode step advances; the next item is
// taken once the sequencer is idle. A run is stepped by a microcode ROM through
// the registered table read port: need check, work copy, then at most P passes.
// Only one item is in work at a time. Reset: max claims, allocations and
// available amounts are cleared by a sweep of MAX_PROCESSES*MAX_RESOURCES table
// entries; cmd.ready stays low until it ends. Stall: a result waits in the
// output register; the sequencer freezes on its next emitting step until the
// receiver takes the waiting result.
module bankers_safety_check_top
    import bsc_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]     cfg_data,
    bsc_cmd_if.sink                   cmd,
    bsc_res_if.source                 res
);

`include "bankers_safety_check_top_defines.svh"

    localparam int PIW   = $clog2(MAX_PROCESSES);
    localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW   = $clog2(MAX_PROCESSES + 1);
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int PCMPW = (PCW > COUNT_BITS) ? PCW : COUNT_BITS;
    localparam int RCMPW = (RCW > COUNT_BITS) ? RCW : COUNT_BITS;
    localparam int PIN   = (PCW > INDEX_BITS) ? PCW : INDEX_BITS;
    localparam int RIN   = (RCW > INDEX_BITS) ? RCW : INDEX_BITS;
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = $clog2(DEPTH);
    localparam int AMW   = (VALUE_BITS > AMOUNT_BITS) ? VALUE_BITS : AMOUNT_BITS;
    localparam int ALW   = VALUE_BITS + 1;
    localparam int ALSW  = VALUE_BITS + 2;
    localparam int WKW   = VALUE_BITS + 4;
    localparam int WSW   = WKW + 1;
    localparam int UCW   = 5;

    typedef enum logic [UCW-1:0] {
        UC_IDLE     = 5'd0,
        UC_MAX      = 5'd1,
        UC_AVAIL    = 5'd2,
        UC_ALLOC    = 5'd3,
        UC_OOB      = 5'd4,
        UC_NC_TEST  = 5'd5,
        UC_NC_ROW   = 5'd6,
        UC_NC_CMP   = 5'd7,
        UC_NC_NEG   = 5'd8,
        UC_NC_NEXTP = 5'd9,
        UC_WI_START = 5'd10,
        UC_WI_ROW   = 5'd11,
        UC_WI_WR    = 5'd12,
        UC_WI_END   = 5'd13,
        UC_PASS     = 5'd14,
        UC_P_TEST   = 5'd15,
        UC_P_INIT   = 5'd16,
        UC_F_ROW    = 5'd17,
        UC_F_CMP    = 5'd18,
        UC_F_DONE   = 5'd19,
        UC_A_ROW    = 5'd20,
        UC_A_ADD    = 5'd21,
        UC_GRANT    = 5'd22,
        UC_P_NEXT   = 5'd23,
        UC_PASS_END = 5'd24,
        UC_UNSAFE   = 5'd25,
        UC_EMPTY    = 5'd26
    } uc_addr_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_P_END,
        C_R_END,
        C_NEG,
        C_NP_ZERO,
        C_R_END_OR_NOFIT,
        C_NOFIT,
        C_LAST_GRANT,
        C_PROGRESS
    } cond_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_CLR,
        CNT_INC
    } cnt_op_t;

    typedef struct packed {
        cond_t    cond;
        logic     jinv;
        uc_addr_t target;
        cnt_op_t  p_op;
        cnt_op_t  r_op;
        logic     emit;
        status_t  status;
        logic     wr_max;
        logic     wr_avail;
        logic     wr_alloc;
        logic     wr_work_init;
        logic     wr_work_add;
        logic     fin_clr;
        logic     fin_set;
        logic     done_clr;
        logic     done_inc;
        logic     prog_clr;
        logic     prog_set;
        logic     fits_load;
        logic     fits_check;
    } uc_word_t;

    // Control store: one word per step; jump to target when cond (xor jinv) holds.
    function automatic uc_word_t uc_rom(input uc_addr_t a);
        uc_word_t w;
        w = '0;
        case (a)
            UC_IDLE:
            begin
            end
            UC_MAX:
            begin
                w.wr_max = 1'b1; w.emit = 1'b1; w.status = ST_ACCEPTED;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_AVAIL:
            begin
                w.wr_avail = 1'b1; w.emit = 1'b1; w.status = ST_ACCEPTED;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_ALLOC:
            begin
                w.wr_alloc = 1'b1; w.emit = 1'b1; w.status = ST_ACCEPTED;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_OOB:
            begin
                w.emit = 1'b1; w.status = ST_OUT_OF_BOUNDS;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_NC_TEST:
            begin
                w.cond = C_P_END; w.target = UC_WI_START;
            end
            UC_NC_ROW:
            begin
                w.cond = C_R_END; w.target = UC_NC_NEXTP;
            end
            UC_NC_CMP:
            begin
                w.r_op = CNT_INC; w.cond = C_NEG; w.jinv = 1'b1; w.target = UC_NC_ROW;
            end
            UC_NC_NEG:
            begin
                w.emit = 1'b1; w.status = ST_NEGATIVE_NEED;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_NC_NEXTP:
            begin
                w.p_op = CNT_INC; w.r_op = CNT_CLR;
                w.cond = C_ALWAYS; w.target = UC_NC_TEST;
            end
            UC_WI_START:
            begin
                w.p_op = CNT_CLR; w.r_op = CNT_CLR; w.fin_clr = 1'b1; w.done_clr = 1'b1;
            end
            UC_WI_ROW:
            begin
                w.cond = C_R_END; w.target = UC_WI_END;
            end
            UC_WI_WR:
            begin
                w.wr_work_init = 1'b1; w.r_op = CNT_INC;
                w.cond = C_ALWAYS; w.target = UC_WI_ROW;
            end
            UC_WI_END:
            begin
                w.cond = C_NP_ZERO; w.target = UC_EMPTY;
            end
            UC_PASS:
            begin
                w.p_op = CNT_CLR; w.prog_clr = 1'b1;
            end
            UC_P_TEST:
            begin
                w.cond = C_P_END; w.target = UC_PASS_END;
            end
            UC_P_INIT:
            begin
                w.fits_load = 1'b1; w.r_op = CNT_CLR;
            end
            UC_F_ROW:
            begin
                w.cond = C_R_END_OR_NOFIT; w.target = UC_F_DONE;
            end
            UC_F_CMP:
            begin
                w.fits_check = 1'b1; w.r_op = CNT_INC;
                w.cond = C_ALWAYS; w.target = UC_F_ROW;
            end
            UC_F_DONE:
            begin
                w.r_op = CNT_CLR; w.cond = C_NOFIT; w.target = UC_P_NEXT;
            end
            UC_A_ROW:
            begin
                w.cond = C_R_END; w.target = UC_GRANT;
            end
            UC_A_ADD:
            begin
                w.wr_work_add = 1'b1; w.r_op = CNT_INC;
                w.cond = C_ALWAYS; w.target = UC_A_ROW;
            end
            UC_GRANT:
            begin
                w.emit = 1'b1; w.status = ST_GRANTED;
                w.fin_set = 1'b1; w.done_inc = 1'b1; w.prog_set = 1'b1;
                w.cond = C_LAST_GRANT; w.target = UC_IDLE;
            end
            UC_P_NEXT:
            begin
                w.p_op = CNT_INC; w.cond = C_ALWAYS; w.target = UC_P_TEST;
            end
            UC_PASS_END:
            begin
                w.cond = C_PROGRESS; w.target = UC_PASS;
            end
            UC_UNSAFE:
            begin
                w.emit = 1'b1; w.status = ST_UNSAFE;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            UC_EMPTY:
            begin
                w.emit = 1'b1; w.status = ST_ACCEPTED;
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS; w.target = UC_IDLE;
            end
        endcase
        return w;
    endfunction

    // Tables
    logic [VALUE_BITS-1:0] max_mem   [DEPTH];
    logic [ALW-1:0]        alloc_mem [DEPTH];
    logic [VALUE_BITS-1:0] avail_mem [MAX_RESOURCES];
    logic [WKW-1:0]        work_mem  [MAX_RESOURCES];

    logic [VALUE_BITS-1:0] max_rd_reg;
    logic [ALW-1:0]        alloc_rd_reg;
    logic [VALUE_BITS-1:0] avail_rd_reg;
    logic [WKW-1:0]        work_rd_reg;

    // Sequencer and datapath state
    uc_addr_t               upc_reg, upc_next;
    logic [COUNT_BITS-1:0]  pc_reg, pc_next;
    logic [COUNT_BITS-1:0]  rc_reg, rc_next;
    logic [PCW-1:0]         p_reg, p_next;
    logic [RCW-1:0]         r_reg, r_next;
    logic [PCW-1:0]         done_reg, done_next;
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic                   fits_reg, fits_next;
    logic                   prog_reg, prog_next;
    logic                   rel_reg, rel_next;
    logic [VALUE_BITS-1:0]  amount_reg, amount_next;
    logic                   clr_busy_reg, clr_busy_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                   res_valid_reg, res_valid_next;
    status_t                res_status_reg, res_status_next;
    logic [INDEX_BITS-1:0]  res_gp_reg, res_gp_next;
    logic                   res_last_reg, res_last_next;

    uc_word_t              uw;
    logic                  cond_hit;
    logic                  jump;
    logic                  can_emit;
    logic                  stall;
    logic                  advance;
    logic                  cmd_fire;
    logic                  res_load;
    logic [PCW-1:0]        np;
    logic [RCW-1:0]        nr;
    logic                  r_end;
    logic                  neg;
    logic                  last_grant;
    logic                  fits_ok;
    logic                  r_in_bad;
    logic                  p_in_bad;
    logic [PIW-1:0]        p_idx;
    logic [RIW-1:0]        r_idx;
    logic [AW-1:0]         cur_addr;
    logic [AW-1:0]         in_addr;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         tbl_waddr;
    logic [RIW-1:0]        avail_waddr;
    logic [AMW-1:0]        amt_ext;
    logic [VALUE_BITS-1:0] amt_sat;
    logic [ALSW-1:0]       alloc_add;
    logic [ALW-1:0]        alloc_add_sat;
    logic [ALW-1:0]        alloc_sub;
    logic [ALW-1:0]        alloc_wdata;
    logic [ALW-1:0]        need;
    logic [WSW-1:0]        work_sum;
    logic [WKW-1:0]        work_wdata;
    logic                  max_we;
    logic                  alloc_we;
    logic                  avail_we;
    logic                  work_we;

    assign uw = uc_rom(upc_reg);

    assign np = (PCMPW'(pc_reg) >= PCMPW'(MAX_PROCESSES)) ? PCW'(MAX_PROCESSES)
                                                          : PCW'(pc_reg);
    assign nr = (RCMPW'(rc_reg) >= RCMPW'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES)
                                                          : RCW'(rc_reg);

    assign p_idx    = p_reg[PIW-1:0];
    assign r_idx    = r_reg[RIW-1:0];
    assign cur_addr = AW'(p_idx) * AW'(MAX_RESOURCES) + AW'(r_idx);
    assign in_addr  = AW'(PIW'(cmd.process_index)) * AW'(MAX_RESOURCES)
                      + AW'(RIW'(cmd.resource_index));
    assign rd_addr  = (upc_reg == UC_IDLE) ? in_addr : cur_addr;

    // Datapath arithmetic
    assign amt_ext       = AMW'(cmd.amount);
    assign amt_sat       = (amt_ext > AMW'({VALUE_BITS{1'b1}})) ? '1
                                                                : amt_ext[VALUE_BITS-1:0];
    assign alloc_add     = ALSW'(alloc_rd_reg) + ALSW'(amount_reg);
    assign alloc_add_sat = alloc_add[ALSW-1] ? '1 : alloc_add[ALW-1:0];
    assign alloc_sub     = (alloc_rd_reg > ALW'(amount_reg)) ? alloc_rd_reg - ALW'(amount_reg)
                                                             : '0;
    assign neg           = alloc_rd_reg > ALW'(max_rd_reg);
    assign need          = ALW'(max_rd_reg) - alloc_rd_reg;
    assign fits_ok       = WKW'(need) <= work_rd_reg;
    assign work_sum      = WSW'(work_rd_reg) + WSW'(alloc_rd_reg);
    assign r_end         = (r_reg == nr);
    assign last_grant    = ((PCW+1)'(done_reg) + (PCW+1)'(1)) == (PCW+1)'(np);

    assign r_in_bad = RIN'(cmd.resource_index) >= RIN'(MAX_RESOURCES);
    assign p_in_bad = PIN'(cmd.process_index) >= PIN'(np);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:          cond_hit = 1'b0;
            C_ALWAYS:         cond_hit = 1'b1;
            C_P_END:          cond_hit = (p_reg == np);
            C_R_END:          cond_hit = r_end;
            C_NEG:            cond_hit = neg;
            C_NP_ZERO:        cond_hit = (np == '0);
            C_R_END_OR_NOFIT: cond_hit = r_end || !fits_reg;
            C_NOFIT:          cond_hit = !fits_reg;
            C_LAST_GRANT:     cond_hit = last_grant;
            C_PROGRESS:       cond_hit = prog_reg;
            default:          cond_hit = 1'b0;
        endcase
    end

    assign jump      = cond_hit ^ uw.jinv;
    assign can_emit  = !res_valid_reg || res.ready;
    assign stall     = uw.emit && !can_emit;
    assign advance   = (upc_reg != UC_IDLE) && !stall;
    assign res_load  = advance && uw.emit;
    assign cmd.ready = (upc_reg == UC_IDLE) && !clr_busy_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Table write ports: the reset sweep owns the max, alloc and avail ports while it runs
    assign max_we      = clr_busy_reg || (advance && uw.wr_max);
    assign alloc_we    = clr_busy_reg || (advance && uw.wr_alloc);
    assign avail_we    = (clr_busy_reg && (clr_cnt_reg < AW'(MAX_RESOURCES)))
                         || (advance && uw.wr_avail);
    assign work_we     = advance && (uw.wr_work_init || uw.wr_work_add);
    assign tbl_waddr   = clr_busy_reg ? clr_cnt_reg : cur_addr;
    assign avail_waddr = clr_busy_reg ? clr_cnt_reg[RIW-1:0] : r_idx;
    assign alloc_wdata = clr_busy_reg ? '0 : (rel_reg ? alloc_sub : alloc_add_sat);
    assign work_wdata  = uw.wr_work_init ? WKW'(avail_rd_reg)
                                         : (work_sum[WSW-1] ? '1 : work_sum[WKW-1:0]);

    always_ff @(posedge clk)
    begin
        if (max_we)
        begin
            max_mem[tbl_waddr] <= clr_busy_reg ? '0 : amount_reg;
        end
        max_rd_reg <= max_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[tbl_waddr] <= alloc_wdata;
        end
        alloc_rd_reg <= alloc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (avail_we)
        begin
            avail_mem[avail_waddr] <= clr_busy_reg ? '0 : amount_reg;
        end
        avail_rd_reg <= avail_mem[r_idx];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[r_idx] <= work_wdata;
        end
        work_rd_reg <= work_mem[r_idx];
    end

    // Next-state logic of the sequencer, datapath registers and result register
    always_comb
    begin
        upc_next        = upc_reg;
        pc_next         = pc_reg;
        rc_next         = rc_reg;
        p_next          = p_reg;
        r_next          = r_reg;
        done_next       = done_reg;
        fin_next        = fin_reg;
        fits_next       = fits_reg;
        prog_next       = prog_reg;
        rel_next        = rel_reg;
        amount_next     = amount_reg;
        clr_busy_next   = clr_busy_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_gp_next     = res_gp_reg;
        res_last_next   = res_last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROCESS_COUNT:  pc_next = cfg_data;
                CFG_RESOURCE_COUNT: rc_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (cmd_fire)
        begin
            amount_next = amt_sat;
            rel_next    = (cmd.action == ACT_RELEASE);
            if (cmd.action == ACT_RUN)
            begin
                p_next   = '0;
                r_next   = '0;
                upc_next = UC_NC_TEST;
            end
            else
            begin
                p_next = PCW'(cmd.process_index);
                r_next = RCW'(cmd.resource_index);
                if (cmd.action > ACT_RUN || r_in_bad)
                begin
                    upc_next = UC_OOB;
                end
                else if (cmd.action == ACT_LOAD_AVAIL)
                begin
                    upc_next = UC_AVAIL;
                end
                else if (p_in_bad)
                begin
                    upc_next = UC_OOB;
                end
                else if (cmd.action == ACT_LOAD_MAX)
                begin
                    upc_next = UC_MAX;
                end
                else
                begin
                    upc_next = UC_ALLOC;
                end
            end
        end
        else if (advance)
        begin
            case (uw.p_op)
                CNT_CLR: p_next = '0;
                CNT_INC: p_next = p_reg + PCW'(1);
                default: p_next = p_reg;
            endcase
            case (uw.r_op)
                CNT_CLR: r_next = '0;
                CNT_INC: r_next = r_reg + RCW'(1);
                default: r_next = r_reg;
            endcase
            if (uw.fin_clr)
            begin
                fin_next = '0;
            end
            if (uw.fin_set)
            begin
                fin_next[p_idx] = 1'b1;
            end
            if (uw.done_clr)
            begin
                done_next = '0;
            end
            if (uw.done_inc)
            begin
                done_next = done_reg + PCW'(1);
            end
            if (uw.prog_clr)
            begin
                prog_next = 1'b0;
            end
            if (uw.prog_set)
            begin
                prog_next = 1'b1;
            end
            if (uw.fits_load)
            begin
                fits_next = !fin_reg[p_idx];
            end
            if (uw.fits_check)
            begin
                fits_next = fits_reg && fits_ok;
            end
            upc_next = jump ? uw.target : uc_addr_t'(UCW'(upc_reg) + UCW'(1));
        end

        if (res_load)
        begin
            res_valid_next  = 1'b1;
            res_status_next = uw.status;
            res_gp_next     = (uw.status == ST_GRANTED) ? INDEX_BITS'(p_reg) : '0;
            res_last_next   = (uw.status == ST_GRANTED) ? last_grant : 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= UC_IDLE;
            pc_reg         <= COUNT_BITS'(16);
            rc_reg         <= COUNT_BITS'(16);
            p_reg          <= '0;
            r_reg          <= '0;
            done_reg       <= '0;
            fin_reg        <= '0;
            fits_reg       <= 1'b0;
            prog_reg       <= 1'b0;
            rel_reg        <= 1'b0;
            amount_reg     <= '0;
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_ACCEPTED;
            res_gp_reg     <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            pc_reg         <= pc_next;
            rc_reg         <= rc_next;
            p_reg          <= p_next;
            r_reg          <= r_next;
            done_reg       <= done_next;
            fin_reg        <= fin_next;
            fits_reg       <= fits_next;
            prog_reg       <= prog_next;
            rel_reg        <= rel_next;
            amount_reg     <= amount_next;
            clr_busy_reg   <= clr_busy_next;
            clr_cnt_reg    <= clr_cnt_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_gp_reg     <= res_gp_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.status          = res_status_reg;
    assign res.granted_process = res_gp_reg;
    assign res.last            = res_last_reg;

    `BSC_ASSERT_IMPL(a_no_item_while_clearing, clr_busy_reg, !cmd.ready, "item taken during table clear")
    `BSC_ASSERT_IMPL(a_result_has_room, res_load, !res_valid_reg || res.ready, "result register overrun")
    `BSC_ASSERT_NEXT(a_one_item_at_a_time, cmd_fire, !cmd.ready, "second item taken while busy")
    `BSC_ASSERT_NEXT(a_last_ends_item, res_load && (uw.status != ST_GRANTED || last_grant), upc_reg == UC_IDLE, "sequencer busy after final result")
    `BSC_ASSERT_IMPL(a_grant_count_bounded, upc_reg == UC_GRANT, done_reg < np, "more grants than processes")

endmodule
